FILE: hw/rtl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants for the quoted token splitter: beat payloads,
// character codes and configuration register indexes.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int CHAR_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int POS_W    = FIELD_W + 1;  // count of characters, holds 65536
  localparam int MAP_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CHAR_W-1:0] QUOTE_CH  = 8'h22;
  localparam logic [CHAR_W-1:0] BSLASH_CH = 8'h5C;
  localparam logic [CHAR_W-1:0] NUL_CH    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_MAP_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MAP_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MAP_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MAP_3 = 3'd3;

  // Space (code 32) is the only separator after reset.
  localparam logic [MAP_W-1:0] SEP_MAP_0_RESET = 64'h0000_0001_0000_0000;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in_string;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] token_offset;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] token_ordinal;
    logic               too_long;
  } out_t;

endpackage

FILE: hw/rtl/quoted_token_splitter.sv
// ----------------------------------------------------------------------------
// quoted_token_splitter
// Splits a byte stream, one character per beat, into tokens separated by a
// configurable set of separators, with double-quoted tokens and backslash
// escapes of the quote. One result beat per finished token.
// ----------------------------------------------------------------------------
// Character beats pass one input register, then one result register. Throughput:
// one character per cycle while no result is stuck behind out_stall; the
// per-character decision between the two registers is a single bitmap lookup.
// Reset (synchronous, active high): all string state clears, the separator
// map returns to space only, both pipeline valids drop.
module quoted_token_splitter
  import qts_pkg::*;
#(
  parameter int MAX_LEN = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  // character beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  // token beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_data
);

  // Positions saturate at the smaller of MAX_LEN and the 16-bit field range.
  localparam int LIMIT = (MAX_LEN < 65536) ? MAX_LEN : 65536;
  localparam logic [POS_W-1:0]   LIMIT_V  = POS_W'(LIMIT);
  localparam logic [FIELD_W-1:0] LIMIT_M1 = FIELD_W'(LIMIT - 1);

  // Separator bitmap, one bit per character code.
  logic [MAP_W-1:0] sep_map_0, sep_map_1, sep_map_2, sep_map_3;
  logic [4*MAP_W-1:0] sep_bits;

  // Input register stage.
  logic s1_valid;
  in_t  s1_data;

  // String state.
  logic               inside_token, inside_token_next;
  logic               in_quotes, in_quotes_next;
  logic [CHAR_W-1:0]  prev_char, prev_char_next;
  logic [FIELD_W-1:0] token_begin, token_begin_next;
  logic [POS_W-1:0]   char_position, char_position_next;
  logic [FIELD_W-1:0] tokens_emitted, tokens_emitted_next;
  logic               overflowed, overflowed_next;

  // Per-character decode.
  logic               out_free;
  logic               s1_adv;
  logic [CHAR_W-1:0]  c;
  logic               last;
  logic               sep;
  logic               opener;
  logic [FIELD_W-1:0] pos_i;
  logic [POS_W-1:0]   pos_i_ext;
  logic [POS_W-1:0]   end_pos;
  logic [POS_W-1:0]   begin_ext;
  logic [POS_W-1:0]   len_raw;
  logic [POS_W-1:0]   quote_begin;
  logic               emit;
  logic [FIELD_W-1:0] emit_begin;
  logic [POS_W-1:0]   emit_len;
  out_t               result;

  // Configuration: always ready, writes beyond the map are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_map_0 <= SEP_MAP_0_RESET;
      sep_map_1 <= '0;
      sep_map_2 <= '0;
      sep_map_3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEP_MAP_0: sep_map_0 <= cfg_data;
        REG_SEP_MAP_1: sep_map_1 <= cfg_data;
        REG_SEP_MAP_2: sep_map_2 <= cfg_data;
        REG_SEP_MAP_3: sep_map_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sep_bits = {sep_map_3, sep_map_2, sep_map_1, sep_map_0};

  // Handshake: the decode stage advances whenever the result register is
  // empty or being drained; the input stage holds only behind a stuck result.
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Per-character decision and state update.
  always_comb begin
    c      = s1_data.char_in;
    last   = s1_data.last_in_string;
    sep    = sep_bits[c];
    opener = (c == QUOTE_CH) && (prev_char != BSLASH_CH);

    inside_token_next   = inside_token;
    in_quotes_next      = in_quotes;
    token_begin_next    = token_begin;
    char_position_next  = char_position;
    tokens_emitted_next = tokens_emitted;
    overflowed_next     = overflowed;

    // Saturate the position once the string runs past the limit.
    if (char_position >= LIMIT_V) begin
      overflowed_next = 1'b1;
      pos_i           = LIMIT_M1;
    end else begin
      pos_i              = char_position[FIELD_W-1:0];
      char_position_next = char_position + POS_W'(1);
    end
    pos_i_ext = {1'b0, pos_i};
    begin_ext = {1'b0, token_begin};

    // Quoted token opens after the quote, or on it at the end of the string.
    quote_begin = last ? pos_i_ext : pos_i_ext + POS_W'(1);
    if (quote_begin > {1'b0, LIMIT_M1}) begin
      quote_begin = {1'b0, LIMIT_M1};
    end

    end_pos    = pos_i_ext;
    emit       = 1'b0;
    emit_begin = token_begin;
    emit_len   = '0;

    if (inside_token) begin
      if (!in_quotes) begin
        if (sep) begin
          emit = 1'b1;
        end else if (last) begin
          emit    = 1'b1;
          end_pos = pos_i_ext + POS_W'(1);
        end
      end else if (opener) begin
        emit           = 1'b1;
        in_quotes_next = 1'b0;
      end
      len_raw = (end_pos >= begin_ext) ? end_pos - begin_ext : '0;
      if (emit) begin
        emit_len          = len_raw;
        inside_token_next = 1'b0;
      end
    end else begin
      len_raw = '0;
      if (!sep) begin
        if (opener) begin
          token_begin_next  = quote_begin[FIELD_W-1:0];
          in_quotes_next    = 1'b1;
          inside_token_next = 1'b1;
        end else if (last) begin
          // Lone character at the end of the string is a token of its own.
          emit       = 1'b1;
          emit_begin = pos_i;
          emit_len   = POS_W'(1);
        end else begin
          token_begin_next  = pos_i;
          inside_token_next = 1'b1;
        end
      end
    end

    result.token_offset  = emit_begin;
    result.token_length  = emit_len[FIELD_W] ? FIELD_MAX : emit_len[FIELD_W-1:0];
    result.token_ordinal = tokens_emitted;
    result.too_long      = overflowed_next;

    if (emit && (tokens_emitted != FIELD_MAX)) begin
      tokens_emitted_next = tokens_emitted + FIELD_W'(1);
    end

    prev_char_next = c;

    // Drop all string state after its last character.
    if (last) begin
      inside_token_next   = 1'b0;
      in_quotes_next      = 1'b0;
      prev_char_next      = NUL_CH;
      token_begin_next    = '0;
      char_position_next  = '0;
      tokens_emitted_next = '0;
      overflowed_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token   <= 1'b0;
      in_quotes      <= 1'b0;
      prev_char      <= NUL_CH;
      token_begin    <= '0;
      char_position  <= '0;
      tokens_emitted <= '0;
      overflowed     <= 1'b0;
    end else if (s1_adv) begin
      inside_token   <= inside_token_next;
      in_quotes      <= in_quotes_next;
      prev_char      <= prev_char_next;
      token_begin    <= token_begin_next;
      char_position  <= char_position_next;
      tokens_emitted <= tokens_emitted_next;
      overflowed     <= overflowed_next;
    end
  end

  // Result register: load on advance, clear once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= emit;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data <= result;
    end
  end

endmodule
